### sv/sbf_pkg.sv
// sbf_pkg: shared types, codes and arithmetic helpers of the stroke Bezier fitter.
// No dependencies; compiled first.
`default_nettype none
package sbf_pkg;

	localparam int PosW   = 24;
	localparam int CfgW   = 16;
	localparam int CfgIdxW = 1;

	localparam logic [1:0] REQ_PRESS   = 2'd0;
	localparam logic [1:0] REQ_MOVE    = 2'd1;
	localparam logic [1:0] REQ_RELEASE = 2'd2;

	localparam logic [CfgIdxW-1:0] CFG_SMOOTHNESS  = 1'b0;
	localparam logic [CfgIdxW-1:0] CFG_MIN_TAN_LEN = 1'b1;

	localparam logic [CfgW-1:0] SMOOTH_RST  = 16'd256;
	localparam logic [CfgW-1:0] MIN_TAN_RST = 16'd512;

	typedef enum logic [4:0] {
		ST_IDLE, ST_SQ_X, ST_SQ_Y, ST_SQ_SUM, ST_SQRT, ST_SCALE,
		ST_TAN_MUL, ST_DIV_LOAD, ST_DIV_RUN, ST_DIV_DONE,
		ST_TSQ_X, ST_TSQ_Y, ST_TSQ_T, ST_TSQ_CMP,
		ST_C1_MUL, ST_C1_ADD, ST_NT_MUL, ST_C2_MUL, ST_C2_ADD, ST_EMIT
	} sbf_state_t;

	// clamp to a signed 24 bit field
	function automatic logic signed [23:0] sat24(input logic signed [41:0] v);
		logic signed [23:0] r;
		if (v > 42'sd8388607) r = 24'sd8388607;
		else if (v < -42'sd8388608) r = -24'sd8388608;
		else r = v[23:0];
		return r;
	endfunction

	// divide by 2^16, nearest, ties away from zero
	function automatic logic signed [40:0] rnd16(input logic signed [55:0] p);
		logic [55:0] mag;
		logic [39:0] q;
		logic signed [40:0] r;
		mag = p[55] ? 56'(-p) : 56'(p);
		q = 40'((mag + 56'd32768) >> 16);
		r = p[55] ? -$signed({1'b0, q}) : $signed({1'b0, q});
		return r;
	endfunction

	// signed, saturated quotient from magnitude, sign and overflow flag
	function automatic logic signed [23:0] div_result(input logic [23:0] quo,
			input logic neg, input logic ovf);
		logic signed [23:0] r;
		if (neg) begin
			if (ovf || quo[23]) r = -24'sd8388608;
			else r = -$signed(quo);
		end else begin
			if (ovf || quo[23]) r = 24'sd8388607;
			else r = $signed(quo);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

### sv/sbf_req_if.sv
// sbf_req_if: pointer event channel (valid/ready plus event kind and position).
// Depends on nothing.
`default_nettype none
interface sbf_req_if;
	logic               valid;
	logic               ready;
	logic        [1:0]  req_type;
	logic signed [23:0] pos_x;
	logic signed [23:0] pos_y;

	modport source (output valid, req_type, pos_x, pos_y, input ready);
	modport sink   (input valid, req_type, pos_x, pos_y, output ready);
endinterface
`default_nettype wire

### sv/sbf_seg_if.sv
// sbf_seg_if: Bezier segment channel (valid/ready plus four points).
// Depends on nothing.
`default_nettype none
interface sbf_seg_if;
	logic               valid;
	logic               ready;
	logic signed [23:0] start_x;
	logic signed [23:0] start_y;
	logic signed [23:0] ctrl1_x;
	logic signed [23:0] ctrl1_y;
	logic signed [23:0] ctrl2_x;
	logic signed [23:0] ctrl2_y;
	logic signed [23:0] end_x;
	logic signed [23:0] end_y;

	modport source (output valid, start_x, start_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y,
		end_x, end_y, input ready);
	modport sink   (input valid, start_x, start_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y,
		end_x, end_y, output ready);
endinterface
`default_nettype wire

### sv/stroke_smooth_bezier_fit.sv
// stroke_smooth_bezier_fit: pointer stroke smoother and cubic Bezier segment fitter.
// Depends on sbf_pkg, sbf_req_if, sbf_seg_if.
//
// Usage: pointer events enter on req (valid/ready; a word moves when both are high).
// A press, an unused kind, a release outside a stroke and a move outside a stroke
// are absorbed in the accepting cycle; ready stays high. A move or release during
// a stroke starts a fit: ready drops while one shared 28x28 multiplier, a
// 2-bit-per-cycle square root and a 1-bit-per-cycle divider run under the
// sequencer below. Every fit first runs two squares, a sum, 25 root steps and the
// scale. The first fit of a stroke then runs two divides (tangent multiply, load,
// 24 divide steps, done) and a tangent length check (three squares, compare); a
// normal fit runs two axis passes with a 24-step divide each, plus emit, and a
// zero-length segment runs both axis passes without the divide, plus emit.
// A fitted segment goes to seg through an output register; the next event is
// accepted while it waits. If a new segment is ready while the old one is still
// held, the sequencer waits in its emit step until seg.ready.
// Config writes (cfg_we, cfg_idx, cfg_wdata) take effect at once; issue them idle.
// Reset (arst_n low) clears the kept points, tangent, stroke flag and any pending
// output word, and restores the smoothness and minimum tangent registers.
`default_nettype none
module stroke_smooth_bezier_fit (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_we,
	input  wire  [sbf_pkg::CfgIdxW-1:0]    cfg_idx,
	input  wire  [sbf_pkg::CfgW-1:0]       cfg_wdata,
	sbf_req_if.sink                        req,
	sbf_seg_if.source                      seg
);
	import sbf_pkg::*;

	sbf_state_t state_q, state_n;

	// config
	logic [15:0] smooth_q, mintan_q;

	// stroke state
	logic signed [23:0] older_x_q, older_y_q, newer_x_q, newer_y_q;
	logic signed [23:0] tan_x_q, tan_y_q;
	logic               tval_q, active_q;

	// working registers
	logic               axis_q;        // 0: X, 1: Y
	logic               first_q;       // first fit of the stroke
	logic               release_q;     // current event ends the stroke
	logic signed [55:0] mul_q;
	logic [49:0]        acc_q;         // square sum, sqrt remainder
	logic [49:0]        res_q;         // sqrt partial root
	logic [4:0]         cnt_q;
	logic [26:0]        scale_q;
	logic [28:0]        rem_q;
	logic [23:0]        nlo_q;
	logic [23:0]        quo_q;
	logic               neg_q, ovf_q;
	logic signed [23:0] c1_x_q, c1_y_q, c2_x_q;

	// output register
	logic               seg_valid_q;
	logic signed [23:0] o_sx_q, o_sy_q, o_c1x_q, o_c1y_q, o_c2x_q, o_c2y_q, o_ex_q, o_ey_q;

	// combinational helpers
	logic               accept;
	logic               start_fit;
	logic signed [24:0] dx_w, dy_w, dsel_w, nmc_w;
	logic signed [23:0] tsel_w, osel_w, nsel_w, c1sel_w;
	logic signed [27:0] mul_a, mul_b;
	logic [28:0]        den_w;
	logic [26:0]        scale_n;
	logic               first_n;
	logic [49:0]        bit_w, try_w;
	logic [40:0]        mmag_w;
	logic [48:0]        num_w;
	logic [29:0]        r2_w;
	logic signed [40:0] rnd_w;
	logic signed [23:0] c1_n, c2_n, divq_w;
	logic signed [24:0] avg_x_s, avg_y_s;
	logic               in_ready;

	assign accept    = req.valid && in_ready;
	assign start_fit = accept && active_q &&
		(req.req_type == REQ_MOVE || req.req_type == REQ_RELEASE);

	assign dx_w    = 25'(newer_x_q) - 25'(older_x_q);
	assign dy_w    = 25'(newer_y_q) - 25'(older_y_q);
	assign dsel_w  = axis_q ? dy_w : dx_w;
	assign tsel_w  = axis_q ? tan_y_q : tan_x_q;
	assign osel_w  = axis_q ? older_y_q : older_x_q;
	assign nsel_w  = axis_q ? newer_y_q : newer_x_q;
	assign c1sel_w = axis_q ? c1_y_q : c1_x_q;
	assign nmc_w   = 25'(nsel_w) - 25'(c1sel_w);
	assign den_w   = 29'(scale_q) + {1'b0, scale_q, 1'b0};

	assign scale_n = 27'(res_q[24:0]) + {1'b0, res_q[24:0], 1'b0};
	assign first_n = !tval_q && (scale_n > 27'd2);

	// sqrt step: bit = 4^cnt
	assign bit_w = 50'(1) << {cnt_q, 1'b0};
	assign try_w = res_q + bit_w;

	// divider load: |diff*s| * 256 + den/2
	assign mmag_w = mul_q[55] ? 41'(-mul_q) : 41'(mul_q);
	assign num_w  = {1'b0, mmag_w[39:0], 8'b0} + 49'(den_w >> 1);
	assign r2_w   = {rem_q, nlo_q[23]};

	assign rnd_w  = rnd16(mul_q);
	assign c1_n   = sat24(42'(osel_w) + 42'(rnd_w));
	assign c2_n   = sat24(42'(nsel_w) - 42'(rnd_w));
	assign divq_w = div_result(quo_q, neg_q, ovf_q);

	// floor average of new position with the older kept point
	assign avg_x_s = 25'(req.pos_x) + 25'(older_x_q);
	assign avg_y_s = 25'(req.pos_y) + 25'(older_y_q);

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE:     if (start_fit) state_n = ST_SQ_X;
			ST_SQ_X:     state_n = ST_SQ_Y;
			ST_SQ_Y:     state_n = ST_SQ_SUM;
			ST_SQ_SUM:   state_n = ST_SQRT;
			ST_SQRT:     if (cnt_q == 5'd0) state_n = ST_SCALE;
			ST_SCALE:    state_n = first_n ? ST_TAN_MUL : ST_C1_MUL;
			ST_TAN_MUL:  state_n = ST_DIV_LOAD;
			ST_DIV_LOAD: state_n = ST_DIV_RUN;
			ST_DIV_RUN:  if (cnt_q == 5'd0) state_n = ST_DIV_DONE;
			ST_DIV_DONE: begin
				if (!first_q) state_n = ST_C2_MUL;
				else if (axis_q) state_n = ST_TSQ_X;
				else state_n = ST_TAN_MUL;
			end
			ST_TSQ_X:    state_n = ST_TSQ_Y;
			ST_TSQ_Y:    state_n = ST_TSQ_T;
			ST_TSQ_T:    state_n = ST_TSQ_CMP;
			ST_TSQ_CMP:  state_n = ST_IDLE;
			ST_C1_MUL:   state_n = ST_C1_ADD;
			ST_C1_ADD:   state_n = (scale_q != '0) ? ST_NT_MUL : ST_C2_MUL;
			ST_NT_MUL:   state_n = ST_DIV_LOAD;
			ST_C2_MUL:   state_n = ST_C2_ADD;
			ST_C2_ADD:   state_n = axis_q ? ST_EMIT : ST_C1_MUL;
			ST_EMIT:     if (!seg_valid_q || seg.ready) state_n = ST_IDLE;
			default:     state_n = ST_IDLE;
		endcase
	end

	// outputs of the sequencer: ready and multiplier operands
	always_comb begin
		in_ready = 1'b0;
		mul_a    = '0;
		mul_b    = '0;
		unique case (state_q)
			ST_IDLE:    in_ready = 1'b1;
			ST_SQ_X:    begin mul_a = 28'(dx_w); mul_b = 28'(dx_w); end
			ST_SQ_Y:    begin mul_a = 28'(dy_w); mul_b = 28'(dy_w); end
			ST_TAN_MUL: begin mul_a = 28'(dsel_w); mul_b = $signed({12'b0, smooth_q}); end
			ST_NT_MUL:  begin mul_a = 28'(nmc_w); mul_b = $signed({12'b0, smooth_q}); end
			ST_C1_MUL,
			ST_C2_MUL:  begin mul_a = 28'(tsel_w); mul_b = $signed({1'b0, scale_q}); end
			ST_TSQ_X:   begin mul_a = 28'(tan_x_q); mul_b = 28'(tan_x_q); end
			ST_TSQ_Y:   begin mul_a = 28'(tan_y_q); mul_b = 28'(tan_y_q); end
			ST_TSQ_T:   begin
				mul_a = $signed({12'b0, mintan_q});
				mul_b = $signed({12'b0, mintan_q});
			end
			default: ;
		endcase
	end

	assign req.ready = in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smooth_q <= SMOOTH_RST;
			mintan_q <= MIN_TAN_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_SMOOTHNESS:  smooth_q <= cfg_wdata;
				CFG_MIN_TAN_LEN: mintan_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// stroke state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			older_x_q <= '0;
			older_y_q <= '0;
			newer_x_q <= '0;
			newer_y_q <= '0;
			tan_x_q   <= '0;
			tan_y_q   <= '0;
			tval_q    <= 1'b0;
			active_q  <= 1'b0;
			release_q <= 1'b0;
		end else begin
			if (accept) begin
				if (req.req_type == REQ_PRESS) begin
					tan_x_q   <= '0;
					tan_y_q   <= '0;
					tval_q    <= 1'b0;
					older_x_q <= req.pos_x;
					older_y_q <= req.pos_y;
					newer_x_q <= req.pos_x;
					newer_y_q <= req.pos_y;
					active_q  <= 1'b1;
				end else if (req.req_type == REQ_MOVE ||
						(req.req_type == REQ_RELEASE && active_q)) begin
					older_x_q <= newer_x_q;
					older_y_q <= newer_y_q;
					newer_x_q <= avg_x_s[24:1];
					newer_y_q <= avg_y_s[24:1];
				end
				release_q <= (req.req_type == REQ_RELEASE);
			end
			// tangent updates along the fit
			if (state_q == ST_DIV_DONE) begin
				if (axis_q) tan_y_q <= divq_w;
				else tan_x_q <= divq_w;
			end
			if (state_q == ST_C1_ADD && scale_q == '0) begin
				if (axis_q) tan_y_q <= '0;
				else tan_x_q <= '0;
			end
			if (state_q == ST_TSQ_CMP) begin
				tval_q <= 1'b1;
				if (acc_q < {mul_q[31:0], 16'b0, 2'b0} >> 2) begin
					tan_x_q <= '0;
					tan_y_q <= '0;
				end
				if (release_q) active_q <= 1'b0;
			end
			if (state_q == ST_EMIT && state_n == ST_IDLE && release_q) active_q <= 1'b0;
		end
	end

	// arithmetic working registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q  <= 1'b0;
			first_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_SQ_Y:   acc_q <= mul_q[49:0];
				ST_SQ_SUM: begin
					acc_q <= acc_q + mul_q[49:0];
					res_q <= '0;
					cnt_q <= 5'd24;
				end
				ST_SQRT: begin
					if (acc_q >= try_w) begin
						acc_q <= acc_q - try_w;
						res_q <= (res_q >> 1) + bit_w;
					end else begin
						res_q <= res_q >> 1;
					end
					cnt_q <= cnt_q - 5'd1;
				end
				ST_SCALE: begin
					scale_q <= scale_n;
					first_q <= first_n;
					axis_q  <= 1'b0;
				end
				ST_DIV_LOAD: begin
					neg_q <= mul_q[55];
					ovf_q <= num_w >= 49'({den_w, 24'b0} >> 4) << 4 &&
						{4'b0, num_w} >= {den_w, 24'b0};
					rem_q <= 29'(num_w[48:24]);
					nlo_q <= num_w[23:0];
					quo_q <= '0;
					cnt_q <= 5'd23;
				end
				ST_DIV_RUN: begin
					if (r2_w >= 30'(den_w)) begin
						rem_q <= 29'(r2_w - 30'(den_w));
						quo_q <= {quo_q[22:0], 1'b1};
					end else begin
						rem_q <= r2_w[28:0];
						quo_q <= {quo_q[22:0], 1'b0};
					end
					nlo_q <= {nlo_q[22:0], 1'b0};
					cnt_q <= cnt_q - 5'd1;
				end
				ST_DIV_DONE: if (first_q && !axis_q) axis_q <= 1'b1;
				ST_TSQ_Y:  acc_q <= mul_q[49:0];
				ST_TSQ_T:  acc_q <= acc_q + mul_q[49:0];
				ST_C1_ADD: begin
					if (axis_q) c1_y_q <= c1_n;
					else c1_x_q <= c1_n;
				end
				ST_C2_ADD: begin
					if (!axis_q) begin
						c2_x_q <= c2_n;
						axis_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// output register: loaded from the emit step, held until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && state_n == ST_IDLE) begin
			seg_valid_q <= 1'b1;
		end else if (seg.ready) begin
			seg_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_C2_ADD && axis_q) o_c2y_q <= c2_n;
		if (state_q == ST_EMIT && state_n == ST_IDLE) begin
			o_sx_q  <= older_x_q;
			o_sy_q  <= older_y_q;
			o_c1x_q <= c1_x_q;
			o_c1y_q <= c1_y_q;
			o_c2x_q <= c2_x_q;
			o_ex_q  <= newer_x_q;
			o_ey_q  <= newer_y_q;
		end
	end

	// ctrl2 Y lands before emit; park it until the emit step loads the rest
	logic signed [23:0] c2y_out_q;
	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && state_n == ST_IDLE) c2y_out_q <= o_c2y_q;
	end

	assign seg.valid   = seg_valid_q;
	assign seg.start_x = o_sx_q;
	assign seg.start_y = o_sy_q;
	assign seg.ctrl1_x = o_c1x_q;
	assign seg.ctrl1_y = o_c1y_q;
	assign seg.ctrl2_x = o_c2x_q;
	assign seg.ctrl2_y = c2y_out_q;
	assign seg.end_x   = o_ex_q;
	assign seg.end_y   = o_ey_q;

endmodule
`default_nettype wire

### sv/sbf_checker.sv
// sbf_checker: port-level assertions for stroke_smooth_bezier_fit, with its bind.
// Depends on sbf_pkg.
`default_nettype none
module sbf_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_ready,
	input wire [1:0]  in_type,
	input wire        out_valid,
	input wire        out_ready,
	input wire [23:0] out_start_x
);
	import sbf_pkg::*;

	// a stalled segment word stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("segment word dropped while stalled");

	// a stalled segment word keeps its start x payload
	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_start_x))
		else $error("segment payload changed while stalled");

	// a new segment only follows a busy fit
	a_fit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("segment appeared without a fit");

	// a press is absorbed at once
	a_press: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_type == REQ_PRESS |=> in_ready)
		else $error("press kept the block busy");

endmodule

bind stroke_smooth_bezier_fit sbf_checker u_sbf_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (req.valid),
	.in_ready   (req.ready),
	.in_type    (req.req_type),
	.out_valid  (seg.valid),
	.out_ready  (seg.ready),
	.out_start_x(seg.start_x)
);
`default_nettype wire
